// ----- rtl/mbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// shared constants, payload types and fixed-point helpers for the
// escape-time unit
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int COUNT_BITS = 10;
   localparam int FRAC_BITS  = 28;
   localparam int IN_W       = 32;

   // internal values are signed q8.frac
   localparam int QW   = FRAC_BITS + 8;
   // operand split for the partial products
   localparam int HW   = (QW + 1) / 2;
   localparam int PP_W = 2 * HW + 2;
   // exact product width, with headroom
   localparam int SW   = 2 * QW + 2;
   // width of the saturating adds
   localparam int AW   = ((QW > IN_W) ? QW : IN_W) + 2;

   localparam logic signed [QW-1:0] Q_HI = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] Q_LO = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [QW:0]   FOUR = (QW+1)'(4) <<< FRAC_BITS;

   localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(500);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   // register index sits above the byte offset
   localparam logic CSR_IDX_MAX_ITER = 1'b0;

   typedef struct packed {
      logic signed [IN_W-1:0] c_real;
      logic signed [IN_W-1:0] c_imag;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic                  escaped;
   } rsp_type;

   // clamp a wide sum into the q8 range
   function automatic logic signed [QW-1:0] sat_q(input logic signed [AW-1:0] v);
      logic signed [QW-1:0] r;
      if (v > AW'(Q_HI)) begin
         r = Q_HI;
      end else if (v < AW'(Q_LO)) begin
         r = Q_LO;
      end else begin
         r = $signed(v[QW-1:0]);
      end
      return r;
   endfunction

   // recombine four partial products into the exact signed product
   function automatic logic signed [SW-1:0] prod_join(
      input logic signed [PP_W-1:0] ll,
      input logic signed [PP_W-1:0] lh,
      input logic signed [PP_W-1:0] hl,
      input logic signed [PP_W-1:0] hh
   );
      logic signed [SW-1:0] e_ll;
      logic signed [SW-1:0] e_lh;
      logic signed [SW-1:0] e_hl;
      logic signed [SW-1:0] e_hh;
      e_ll = SW'(ll);
      e_lh = SW'(lh);
      e_hl = SW'(hl);
      e_hh = SW'(hh);
      return (e_hh <<< (2 * HW)) + ((e_lh + e_hl) <<< HW) + e_ll;
   endfunction

   // floor shift of a product, then clamp; dbl gives twice the product
   function automatic logic signed [QW-1:0] sat_prod(
      input logic signed [SW-1:0] p,
      input logic                 dbl
   );
      logic signed [SW-1:0] s;
      logic signed [QW-1:0] r;
      s = dbl ? (p >>> (FRAC_BITS - 1)) : (p >>> FRAC_BITS);
      if (s > SW'(Q_HI)) begin
         r = Q_HI;
      end else if (s < SW'(Q_LO)) begin
         r = Q_LO;
      end else begin
         r = $signed(s[QW-1:0]);
      end
      return r;
   endfunction

endpackage

// ----- rtl/mbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_front
// command intake: takes points on start and holds them in a short queue
// until the iteration core is free
// ----------------------------------------------------------------------------
module mbe_front
   import mbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  logic    pop,
   output logic    q_valid,
   output req_type q_data
);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   req_type             entry_ff [QUEUE_DEPTH];

   logic push;
   logic take;

   assign busy    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign take    = pop && q_valid;
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ----- rtl/mbe_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_core
// iteration engine: z = z*z + c with split multipliers, through mul, sum and add states each step
// ----------------------------------------------------------------------------
module mbe_core
   import mbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_BITS-1:0] limit,
   input  logic                  q_valid,
   input  req_type               q_data,
   output logic                  pop,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_ADD  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic signed [IN_W-1:0] cr_ff, cr_in;
   logic signed [IN_W-1:0] ci_ff, ci_in;
   logic signed [QW-1:0]   x_ff, x_in;
   logic signed [QW-1:0]   y_ff, y_in;
   logic [COUNT_BITS-1:0]  k_ff, k_in;

   // partial products: squares need three, the cross product four
   logic signed [PP_W-1:0] xx_ll_ff, xx_lh_ff, xx_hh_ff;
   logic signed [PP_W-1:0] yy_ll_ff, yy_lh_ff, yy_hh_ff;
   logic signed [PP_W-1:0] xy_ll_ff, xy_lh_ff, xy_hl_ff, xy_hh_ff;

   logic signed [QW-1:0] xx_ff, xx_in;
   logic signed [QW-1:0] yy_ff, yy_in;
   logic signed [QW-1:0] xy2_ff, xy2_in;

   logic signed [HW:0] xl, xh, yl, yh;
   logic signed [QW:0] mag2;
   logic signed [AW-1:0] nx_sum, ny_sum;
   logic escape_now;

   assign xl = $signed({1'b0, x_ff[HW-1:0]});
   assign yl = $signed({1'b0, y_ff[HW-1:0]});
   assign xh = $signed({{(2*HW+1-QW){x_ff[QW-1]}}, x_ff[QW-1:HW]});
   assign yh = $signed({{(2*HW+1-QW){y_ff[QW-1]}}, y_ff[QW-1:HW]});

   assign mag2   = (QW+1)'(xx_ff) + (QW+1)'(yy_ff);
   assign nx_sum = AW'(xx_ff) - AW'(yy_ff) + AW'(cr_ff);
   assign ny_sum = AW'(xy2_ff) + AW'(ci_ff);
   assign escape_now = (k_ff != '0) && (mag2 > FOUR);

   assign pop       = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      xy2_in       = xy2_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cr_in = q_data.c_real;
               ci_in = q_data.c_imag;
               x_in  = sat_q(AW'(q_data.c_real));
               y_in  = sat_q(AW'(q_data.c_imag));
               k_in  = '0;
               if (limit == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.iteration_count = '0;
                  rsp_data_in.escaped         = 1'b0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            xx_in    = sat_prod(prod_join(xx_ll_ff, xx_lh_ff, xx_lh_ff, xx_hh_ff), 1'b0);
            yy_in    = sat_prod(prod_join(yy_ll_ff, yy_lh_ff, yy_lh_ff, yy_hh_ff), 1'b0);
            xy2_in   = sat_prod(prod_join(xy_ll_ff, xy_lh_ff, xy_hl_ff, xy_hh_ff), 1'b1);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            priority if (escape_now) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.iteration_count = k_ff - 1'b1;
               rsp_data_in.escaped         = 1'b1;
               state_in = ST_IDLE;
            end else if (k_ff == limit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.iteration_count = limit;
               rsp_data_in.escaped         = 1'b0;
               state_in = ST_IDLE;
            end else begin
               x_in     = sat_q(nx_sum);
               y_in     = sat_q(ny_sum);
               k_in     = k_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      xy2_ff      <= xy2_in;
   end

   // partial products of the current z, registered before recombination
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         xx_ll_ff <= PP_W'(xl) * PP_W'(xl);
         xx_lh_ff <= PP_W'(xl) * PP_W'(xh);
         xx_hh_ff <= PP_W'(xh) * PP_W'(xh);
         yy_ll_ff <= PP_W'(yl) * PP_W'(yl);
         yy_lh_ff <= PP_W'(yl) * PP_W'(yh);
         yy_hh_ff <= PP_W'(yh) * PP_W'(yh);
         xy_ll_ff <= PP_W'(xl) * PP_W'(yl);
         xy_lh_ff <= PP_W'(xl) * PP_W'(yh);
         xy_hl_ff <= PP_W'(xh) * PP_W'(yl);
         xy_hh_ff <= PP_W'(xh) * PP_W'(yh);
      end
   end

endmodule

// ----- rtl/mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time unit for one complex point per command, fixed point q4.28 in
// ----------------------------------------------------------------------------
// usage:
//  - command channel: a point (req_data) transfers on a rising edge with start
//    high and busy low; up to two points wait in the intake queue, busy is
//    high while that queue is full
//  - result channel: rsp_valid pulses for one cycle with rsp_data; the
//    receiver cannot stall, so each result must be taken in that cycle
//  - register port: max_iterations at byte address 0, apb-style, pready tied
//    high; write it only while no point is in flight
//  - timing: each step of z = z*z + c passes through partial products,
//    then recombine and truncate, then saturating add and escape test
//  - points are worked on one at a time in arrival order; the queue lets
//    further commands transfer while the core is busy, until it is full
//  - reset: synchronous, clears the queue and the core and sets the
//    iteration limit to 500
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
   import mbe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   // result channel
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [COUNT_BITS-1:0] max_iter_ff, max_iter_in;
   logic                  csr_hit;
   logic                  csr_write;

   logic    q_valid;
   logic    q_pop;
   req_type q_data;

   // register index lives above the byte offset
   assign csr_hit   = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_MAX_ITER);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? CSR_DATA_BITS'(max_iter_ff) : '0;

   // limit takes the low bits of the written word
   assign max_iter_in = csr_write ? pwdata[COUNT_BITS-1:0] : max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   // intake and queue
   mbe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_data   (q_data)
   );

   // iteration engine, drives the result strobe directly
   mbe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .limit     (max_iter_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
